// File: src/prs_pkg.sv
// Shared constants, sequencer state type and store control struct for the
// polyline equal-arc resampler. No dependencies.
package prs_pkg;

   localparam int MAX_POINTS = 256;
   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int CNT_W      = ADDR_W + 1;
   localparam int MAX_STEPS  = 63;
   localparam int STEPS_W    = 6;
   localparam int COORD_W    = 24;
   localparam int LEN_W      = 26;
   localparam int TOTAL_W    = 34;
   localparam int SQ_W       = 50;
   localparam int DIV_N_W    = 58;
   localparam int DIV_D_W    = 34;
   localparam int DEN_W      = 32;
   localparam int TGT_W      = 40;
   localparam int MUL_A_W    = 26;
   localparam int MUL_B_W    = 32;
   localparam int MUL_P_W    = 58;

   localparam logic [23:0] STEP_RESET = 24'd256;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SQ_MX,
      ST_SQ_MY,
      ST_SQ_ADD,
      ST_SQ_WAIT,
      ST_FIN,
      ST_STEPS_START,
      ST_STEPS_WAIT,
      ST_FIRST_RD,
      ST_FIRST_PUT,
      ST_K_START,
      ST_WALK_RD,
      ST_WALK_MUL,
      ST_WALK_CMP,
      ST_PT_RD0,
      ST_PT_RD1,
      ST_PT_RD2,
      ST_LERP_MUL,
      ST_LERP_START,
      ST_LERP_WAIT,
      ST_PUT_MID,
      ST_LAST_RD,
      ST_LAST_PUT
   } state_type;

   typedef struct packed {
      logic              pt_we;
      logic [ADDR_W-1:0] pt_addr;
      logic              len_we;
      logic [ADDR_W-1:0] len_addr;
      logic [ADDR_W-1:0] rd_addr;
   } store_ctl_type;

endpackage

// File: src/prs_req_if.sv
// Request channel: one polyline vertex per request.
// Depends on nothing.
interface prs_req_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] point_x;
   logic signed [23:0] point_y;
   logic               final_point;
   logic               closed;

   modport source (output valid, point_x, point_y, final_point, closed, input ready);
   modport sink   (input valid, point_x, point_y, final_point, closed, output ready);
endinterface

// File: src/prs_rsp_if.sv
// Response channel: one resampled point per transfer.
// Depends on nothing.
interface prs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] out_x;
   logic signed [23:0] out_y;
   logic               last_out;
   logic               truncated;

   modport source (output valid, out_x, out_y, last_out, truncated, input ready);
   modport sink   (input valid, out_x, out_y, last_out, truncated, output ready);
endinterface

// File: src/polyline_equal_arc_resampler.sv
// Top level of the polyline equal-arc resampler: sequencer, shared multiplier,
// output register. Depends on prs_pkg, prs_req_if, prs_rsp_if, prs_store,
// prs_sqrt and prs_div.
//
// Vertices arrive one request at a time; req_chan.ready is high only while the
// sequencer is idle. A vertex that opens a segment waits on the 25-step square
// root; a dropped or first vertex skips it. On the final vertex the step count
// costs one pass of the shared divider, and each interior point then costs up
// to two such passes (x and y) plus a read, multiply and compare of segment
// walking per segment passed; end points need no divider pass. A finished
// point sits in an output register, and the next request is taken while the
// last point waits.
module polyline_equal_arc_resampler (
   input  logic        clock,
   input  logic        reset,
   prs_req_if.sink     req_chan,
   prs_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic [23:0] csr_wdata
);

   localparam int AW = prs_pkg::ADDR_W;
   localparam int CW = prs_pkg::CNT_W;
   localparam int XW = prs_pkg::COORD_W;

   prs_pkg::state_type state_ff, state_in;

   logic [CW-1:0]               cnt_ff;
   logic                        ovf_ff;
   logic [prs_pkg::TOTAL_W-1:0] total_ff;
   logic [23:0]                 step_ff;
   logic signed [XW-1:0]        last_x_ff, last_y_ff;
   logic [XW-1:0]               ux_ff, uy_ff;
   logic [AW-1:0]               seg_addr_ff;
   logic                        fin_ff, closed_ff, trunc_ff;
   logic [CW-1:0]               n_ff;
   logic [prs_pkg::STEPS_W-1:0] steps_ff, k_ff;
   logic [AW-1:0]               idx_ff;
   logic [prs_pkg::TGT_W-1:0]   tgt_ff, alongs_ff;
   logic [prs_pkg::DEN_W-1:0]   den_ff, num_ff;
   logic signed [XW-1:0]        ax_ff, ay_ff, bx_ff, by_ff, res_x_ff, res_y_ff;
   logic                        axis_ff, neg_ff;
   logic [prs_pkg::SQ_W-1:0]    sq_acc_ff;
   logic [prs_pkg::MUL_P_W-1:0] mul_q_ff;

   logic                        out_valid_ff;
   logic signed [XW-1:0]        out_x_ff, out_y_ff;
   logic                        out_last_ff, out_trunc_ff;

   prs_pkg::store_ctl_type      ctl;
   logic signed [XW-1:0]        rd_x, rd_y;
   logic [prs_pkg::LEN_W-1:0]   rd_len;

   logic                        sq_start, sq_done;
   logic [prs_pkg::SQ_W-1:0]    sq_op;
   logic [prs_pkg::LEN_W-1:0]   sq_root;

   logic                        dv_start, dv_done;
   logic [prs_pkg::DIV_N_W-1:0] dv_n, dv_q;
   logic [prs_pkg::DIV_D_W-1:0] dv_d;

   logic [prs_pkg::MUL_A_W-1:0] mul_a;
   logic [prs_pkg::MUL_B_W-1:0] mul_b;

   logic                        accept, out_free, emit;
   logic signed [XW-1:0]        emit_x, emit_y;
   logic                        emit_last;
   logic signed [XW:0]          dx, dy, dl;
   logic [XW-1:0]               mag;
   logic [23:0]                 s_eff;
   logic [prs_pkg::TGT_W-1:0]   num_full;
   logic [prs_pkg::DEN_W-1:0]   den_now;
   logic                        advance;
   logic [XW-1:0]               off;
   logic signed [XW-1:0]        lerp_res;

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !out_valid_ff || rsp_chan.ready;

   assign dx = {req_chan.point_x[XW-1], req_chan.point_x} - {last_x_ff[XW-1], last_x_ff};
   assign dy = {req_chan.point_y[XW-1], req_chan.point_y} - {last_y_ff[XW-1], last_y_ff};
   assign dl = axis_ff ? ({by_ff[XW-1], by_ff} - {ay_ff[XW-1], ay_ff})
                       : ({bx_ff[XW-1], bx_ff} - {ax_ff[XW-1], ax_ff});
   assign mag = dl[XW] ? XW'(-dl) : dl[XW-1:0];

   assign s_eff    = (step_ff == '0) ? 24'd1 : step_ff;
   assign num_full = tgt_ff - alongs_ff;
   assign den_now  = mul_q_ff[prs_pkg::DEN_W-1:0];
   assign advance  = (({2'b00, idx_ff} + 10'd2) < {1'b0, n_ff})
                     && (num_full > {8'b0, den_now});
   assign off      = neg_ff ? XW'(-dv_q[XW-1:0]) : dv_q[XW-1:0];
   assign lerp_res = (axis_ff ? ay_ff : ax_ff) + $signed(off);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         prs_pkg::ST_IDLE: begin
            if (accept) begin
               if (cnt_ff < CW'(prs_pkg::MAX_POINTS) && cnt_ff != '0) begin
                  state_in = prs_pkg::ST_SQ_MX;
               end else begin
                  state_in = prs_pkg::ST_FIN;
               end
            end
         end
         prs_pkg::ST_SQ_MX:   state_in = prs_pkg::ST_SQ_MY;
         prs_pkg::ST_SQ_MY:   state_in = prs_pkg::ST_SQ_ADD;
         prs_pkg::ST_SQ_ADD:  state_in = prs_pkg::ST_SQ_WAIT;
         prs_pkg::ST_SQ_WAIT: if (sq_done) state_in = prs_pkg::ST_FIN;
         prs_pkg::ST_FIN: begin
            if (!fin_ff || cnt_ff < CW'(2)) begin
               state_in = prs_pkg::ST_IDLE;
            end else begin
               state_in = prs_pkg::ST_STEPS_START;
            end
         end
         prs_pkg::ST_STEPS_START: state_in = prs_pkg::ST_STEPS_WAIT;
         prs_pkg::ST_STEPS_WAIT:  if (dv_done) state_in = prs_pkg::ST_FIRST_RD;
         prs_pkg::ST_FIRST_RD:    state_in = prs_pkg::ST_FIRST_PUT;
         prs_pkg::ST_FIRST_PUT:   if (out_free) state_in = prs_pkg::ST_K_START;
         prs_pkg::ST_K_START: begin
            if (k_ff == steps_ff) begin
               state_in = closed_ff ? prs_pkg::ST_IDLE : prs_pkg::ST_LAST_RD;
            end else begin
               state_in = prs_pkg::ST_WALK_RD;
            end
         end
         prs_pkg::ST_WALK_RD:  state_in = prs_pkg::ST_WALK_MUL;
         prs_pkg::ST_WALK_MUL: state_in = prs_pkg::ST_WALK_CMP;
         prs_pkg::ST_WALK_CMP: begin
            state_in = advance ? prs_pkg::ST_WALK_RD : prs_pkg::ST_PT_RD0;
         end
         prs_pkg::ST_PT_RD0: state_in = prs_pkg::ST_PT_RD1;
         prs_pkg::ST_PT_RD1: state_in = prs_pkg::ST_PT_RD2;
         prs_pkg::ST_PT_RD2: begin
            state_in = (den_ff == '0) ? prs_pkg::ST_PUT_MID : prs_pkg::ST_LERP_MUL;
         end
         prs_pkg::ST_LERP_MUL:   state_in = prs_pkg::ST_LERP_START;
         prs_pkg::ST_LERP_START: state_in = prs_pkg::ST_LERP_WAIT;
         prs_pkg::ST_LERP_WAIT: begin
            if (dv_done) begin
               state_in = axis_ff ? prs_pkg::ST_PUT_MID : prs_pkg::ST_LERP_MUL;
            end
         end
         prs_pkg::ST_PUT_MID:  if (out_free) state_in = prs_pkg::ST_K_START;
         prs_pkg::ST_LAST_RD:  state_in = prs_pkg::ST_LAST_PUT;
         prs_pkg::ST_LAST_PUT: if (out_free) state_in = prs_pkg::ST_IDLE;
         default: state_in = prs_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_chan.ready = (state_ff == prs_pkg::ST_IDLE);
      ctl.pt_we    = 1'b0;
      ctl.pt_addr  = cnt_ff[AW-1:0];
      ctl.len_we   = 1'b0;
      ctl.len_addr = seg_addr_ff;
      ctl.rd_addr  = idx_ff;
      sq_start  = 1'b0;
      sq_op     = sq_acc_ff + mul_q_ff[prs_pkg::SQ_W-1:0];
      dv_start  = 1'b0;
      dv_n      = {{(prs_pkg::DIV_N_W-prs_pkg::TOTAL_W-2){1'b0}},
                   {1'b0, total_ff, 1'b0} + {12'b0, s_eff}};
      dv_d      = {{(prs_pkg::DIV_D_W-25){1'b0}}, s_eff, 1'b0};
      mul_a     = {2'b00, ux_ff};
      mul_b     = {8'b0, ux_ff};
      emit      = 1'b0;
      emit_x    = rd_x;
      emit_y    = rd_y;
      emit_last = 1'b1;
      case (state_ff)
         prs_pkg::ST_IDLE: begin
            ctl.pt_we = accept && (cnt_ff < CW'(prs_pkg::MAX_POINTS));
         end
         prs_pkg::ST_SQ_MY: begin
            mul_a = {2'b00, uy_ff};
            mul_b = {8'b0, uy_ff};
         end
         prs_pkg::ST_SQ_ADD:  sq_start = 1'b1;
         prs_pkg::ST_SQ_WAIT: ctl.len_we = sq_done;
         prs_pkg::ST_STEPS_START: dv_start = 1'b1;
         prs_pkg::ST_FIRST_RD: ctl.rd_addr = '0;
         prs_pkg::ST_FIRST_PUT: begin
            ctl.rd_addr = '0;
            emit        = out_free;
            emit_last   = closed_ff && (steps_ff == prs_pkg::STEPS_W'(1));
         end
         prs_pkg::ST_WALK_MUL: begin
            mul_a = rd_len;
            mul_b = {{(prs_pkg::MUL_B_W-prs_pkg::STEPS_W){1'b0}}, steps_ff};
         end
         prs_pkg::ST_PT_RD1: ctl.rd_addr = idx_ff + 1'b1;
         prs_pkg::ST_LERP_MUL: begin
            mul_a = {2'b00, mag};
            mul_b = num_ff;
         end
         prs_pkg::ST_LERP_START: begin
            dv_start = 1'b1;
            dv_n     = {mul_q_ff[prs_pkg::DIV_N_W-2:0], 1'b0}
                       + {{(prs_pkg::DIV_N_W-prs_pkg::DEN_W){1'b0}}, den_ff};
            dv_d     = {1'b0, den_ff, 1'b0};
         end
         prs_pkg::ST_PUT_MID: begin
            emit      = out_free;
            emit_x    = res_x_ff;
            emit_y    = res_y_ff;
            emit_last = closed_ff && ({1'b0, k_ff} + 7'd1 == {1'b0, steps_ff});
         end
         prs_pkg::ST_LAST_RD: ctl.rd_addr = AW'(n_ff - 1'b1);
         prs_pkg::ST_LAST_PUT: begin
            ctl.rd_addr = AW'(n_ff - 1'b1);
            emit        = out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prs_pkg::ST_IDLE;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         total_ff     <= '0;
         step_ff      <= prs_pkg::STEP_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) step_ff <= csr_wdata;
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            prs_pkg::ST_IDLE: begin
               if (accept) begin
                  if (cnt_ff < CW'(prs_pkg::MAX_POINTS)) begin
                     cnt_ff <= cnt_ff + 1'b1;
                  end else begin
                     ovf_ff <= 1'b1;
                  end
               end
            end
            prs_pkg::ST_SQ_WAIT: begin
               if (sq_done) total_ff <= total_ff + prs_pkg::TOTAL_W'(sq_root);
            end
            prs_pkg::ST_FIN: begin
               if (fin_ff) begin
                  cnt_ff <= '0;
                  ovf_ff <= 1'b0;
                  if (cnt_ff < CW'(2)) total_ff <= '0;
               end
            end
            prs_pkg::ST_K_START: begin
               if (k_ff == steps_ff && closed_ff) total_ff <= '0;
            end
            prs_pkg::ST_LAST_PUT: begin
               if (out_free) total_ff <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      mul_q_ff <= mul_a * mul_b;
      if (emit) begin
         out_x_ff     <= emit_x;
         out_y_ff     <= emit_y;
         out_last_ff  <= emit_last;
         out_trunc_ff <= trunc_ff;
      end
      case (state_ff)
         prs_pkg::ST_IDLE: begin
            if (accept) begin
               fin_ff      <= req_chan.final_point;
               closed_ff   <= req_chan.closed;
               last_x_ff   <= req_chan.point_x;
               last_y_ff   <= req_chan.point_y;
               ux_ff       <= dx[XW] ? XW'(-dx) : dx[XW-1:0];
               uy_ff       <= dy[XW] ? XW'(-dy) : dy[XW-1:0];
               seg_addr_ff <= AW'(cnt_ff - 1'b1);
            end
         end
         prs_pkg::ST_SQ_MY: sq_acc_ff <= mul_q_ff[prs_pkg::SQ_W-1:0];
         prs_pkg::ST_FIN: begin
            n_ff     <= cnt_ff;
            trunc_ff <= ovf_ff;
         end
         prs_pkg::ST_STEPS_WAIT: begin
            idx_ff    <= '0;
            alongs_ff <= '0;
            tgt_ff    <= '0;
            k_ff      <= prs_pkg::STEPS_W'(1);
            // the quotient is only meaningful once the divider is done
            if (dv_done) begin
               if (dv_q == '0) begin
                  steps_ff <= prs_pkg::STEPS_W'(1);
                  trunc_ff <= 1'b1;
               end else if (dv_q > prs_pkg::DIV_N_W'(prs_pkg::MAX_STEPS)) begin
                  steps_ff <= prs_pkg::STEPS_W'(prs_pkg::MAX_STEPS);
                  trunc_ff <= 1'b1;
               end else begin
                  steps_ff <= dv_q[prs_pkg::STEPS_W-1:0];
               end
            end
         end
         prs_pkg::ST_K_START: tgt_ff <= tgt_ff + prs_pkg::TGT_W'(total_ff);
         prs_pkg::ST_WALK_CMP: begin
            if (advance) begin
               alongs_ff <= alongs_ff + prs_pkg::TGT_W'(den_now);
               idx_ff    <= idx_ff + 1'b1;
            end else begin
               den_ff <= den_now;
               num_ff <= (num_full > {8'b0, den_now}) ? den_now
                                                      : num_full[prs_pkg::DEN_W-1:0];
            end
         end
         prs_pkg::ST_PT_RD1: begin
            ax_ff <= rd_x;
            ay_ff <= rd_y;
         end
         prs_pkg::ST_PT_RD2: begin
            bx_ff    <= rd_x;
            by_ff    <= rd_y;
            axis_ff  <= 1'b0;
            res_x_ff <= ax_ff;
            res_y_ff <= ay_ff;
         end
         prs_pkg::ST_LERP_MUL: neg_ff <= dl[XW];
         prs_pkg::ST_LERP_WAIT: begin
            if (dv_done) begin
               if (axis_ff) begin
                  res_y_ff <= lerp_res;
               end else begin
                  res_x_ff <= lerp_res;
                  axis_ff  <= 1'b1;
               end
            end
         end
         prs_pkg::ST_PUT_MID: begin
            if (out_free) k_ff <= k_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.out_x     = out_x_ff;
   assign rsp_chan.out_y     = out_y_ff;
   assign rsp_chan.last_out  = out_last_ff;
   assign rsp_chan.truncated = out_trunc_ff;

   prs_store u_store (
      .clock  (clock),
      .ctl    (ctl),
      .wr_x   (req_chan.point_x),
      .wr_y   (req_chan.point_y),
      .wr_len (sq_root),
      .rd_x   (rd_x),
      .rd_y   (rd_y),
      .rd_len (rd_len)
   );

   prs_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .operand (sq_op),
      .done    (sq_done),
      .root    (sq_root)
   );

   prs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dv_start),
      .dividend (dv_n),
      .divisor  (dv_d),
      .done     (dv_done),
      .quotient (dv_q)
   );

endmodule

// File: src/prs_store.sv
// Vertex and segment length memories, one shared registered read port.
// Depends on prs_pkg.
module prs_store (
   input  logic                              clock,
   input  prs_pkg::store_ctl_type            ctl,
   input  logic signed [prs_pkg::COORD_W-1:0] wr_x,
   input  logic signed [prs_pkg::COORD_W-1:0] wr_y,
   input  logic [prs_pkg::LEN_W-1:0]         wr_len,
   output logic signed [prs_pkg::COORD_W-1:0] rd_x,
   output logic signed [prs_pkg::COORD_W-1:0] rd_y,
   output logic [prs_pkg::LEN_W-1:0]         rd_len
);

   logic signed [prs_pkg::COORD_W-1:0] mem_x [prs_pkg::MAX_POINTS];
   logic signed [prs_pkg::COORD_W-1:0] mem_y [prs_pkg::MAX_POINTS];
   logic [prs_pkg::LEN_W-1:0]          mem_len [prs_pkg::MAX_POINTS];

   always_ff @(posedge clock) begin
      if (ctl.pt_we) begin
         mem_x[ctl.pt_addr] <= wr_x;
         mem_y[ctl.pt_addr] <= wr_y;
      end
      if (ctl.len_we) begin
         mem_len[ctl.len_addr] <= wr_len;
      end
      rd_x   <= mem_x[ctl.rd_addr];
      rd_y   <= mem_y[ctl.rd_addr];
      rd_len <= mem_len[ctl.rd_addr];
   end

endmodule

// File: src/prs_sqrt.sv
// Bit-serial integer square root, two radicand bits per cycle, rounded
// to nearest. Depends on prs_pkg.
module prs_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [prs_pkg::SQ_W-1:0]      operand,
   output logic                          done,
   output logic [prs_pkg::LEN_W-1:0]     root
);

   logic [prs_pkg::SQ_W-1:0] rem_ff;
   logic [prs_pkg::SQ_W-1:0] root_ff;
   logic [prs_pkg::SQ_W-1:0] bit_ff;
   logic                     busy_ff;
   logic                     done_ff;
   logic [prs_pkg::SQ_W-1:0] trial;
   logic [prs_pkg::SQ_W-1:0] rounded;

   assign trial   = root_ff + bit_ff;
   assign rounded = root_ff + {{(prs_pkg::SQ_W-1){1'b0}}, (rem_ff > root_ff)};
   assign root    = rounded[prs_pkg::LEN_W-1:0];
   assign done    = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && bit_ff[0]) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= operand;
         root_ff <= '0;
         bit_ff  <= {2'b01, {(prs_pkg::SQ_W-2){1'b0}}};
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_ff  <= rem_ff - trial;
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

endmodule

// File: src/prs_div.sv
// Restoring divider, one quotient bit per cycle, shared by the step count
// and the interpolation. Depends on prs_pkg.
module prs_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [prs_pkg::DIV_N_W-1:0]   dividend,
   input  logic [prs_pkg::DIV_D_W-1:0]   divisor,
   output logic                          done,
   output logic [prs_pkg::DIV_N_W-1:0]   quotient
);

   localparam int CW = $clog2(prs_pkg::DIV_N_W);

   logic [prs_pkg::DIV_N_W-1:0] q_ff;
   logic [prs_pkg::DIV_D_W-1:0] rem_ff;
   logic [prs_pkg::DIV_D_W-1:0] d_ff;
   logic [CW-1:0]               cnt_ff;
   logic                        busy_ff;
   logic                        done_ff;
   logic [prs_pkg::DIV_D_W:0]   shifted;
   logic                        fits;

   assign shifted  = {rem_ff, q_ff[prs_pkg::DIV_N_W-1]};
   assign fits     = shifted >= {1'b0, d_ff};
   assign done     = done_ff;
   assign quotient = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(prs_pkg::DIV_N_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= dividend;
         rem_ff <= '0;
         d_ff   <= divisor;
      end else if (busy_ff) begin
         q_ff <= {q_ff[prs_pkg::DIV_N_W-2:0], fits};
         if (fits) begin
            rem_ff <= prs_pkg::DIV_D_W'(shifted - {1'b0, d_ff});
         end else begin
            rem_ff <= shifted[prs_pkg::DIV_D_W-1:0];
         end
      end
   end

endmodule

// File: src/prs_checker.sv
// Port-level checks for the resampler, attached to the top level by bind.
// Depends on polyline_equal_arc_resampler.
module prs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_final,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [23:0] rsp_x
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_x))
      else $error("response dropped or changed while stalled");

   // one request at a time
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in progress");

   // a non-final vertex starts no response
   a_no_rsp_nonfinal: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_final |=> !$rose(rsp_valid))
      else $error("response raised by a non-final vertex");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind polyline_equal_arc_resampler prs_checker u_prs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_final (req_chan.final_point),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_x     (rsp_chan.out_x)
);
